[hw/rtl/irmpd_pkg.sv]
// Shared types, timing windows and helper functions of the infrared remote decoder.
package irmpd_pkg;

	localparam int unsigned TicksW = 16;
	localparam int unsigned CountW = 6;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	localparam logic [2:0] FMT_NEC  = 3'd0;
	localparam logic [2:0] FMT_SIRC = 3'd1;
	localparam logic [2:0] FMT_RC5  = 3'd2;
	localparam logic [2:0] FMT_JAP  = 3'd3;
	localparam logic [2:0] FMT_F45  = 3'd4;

	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_BIT_ERR = 2'd1;
	localparam logic [1:0] ST_VALID   = 2'd2;

	localparam logic [CountW-1:0] LEN_SHORT = 6'd12;
	localparam logic [CountW-1:0] LEN_JAP   = 6'd48;
	localparam logic [CountW-1:0] LEN_STD   = 6'd32;
	localparam logic [CountW-1:0] SIRC_LAST = 6'd11;

	typedef logic [TicksW-1:0] ticks_t;

	typedef struct packed {
		logic [1:0]        phase;
		ticks_t            header_mark;
		logic [2:0]        fmt;
		ticks_t            bit_mark;
		logic              mark_pending;
		logic [31:0]       shift_high;
		logic [15:0]       shift_low;
		logic [CountW-1:0] bit_counter;
		logic              manchester_prev;
	} dec_state_t;

	// The Manchester history starts at the value of the RC5 start bit.
	localparam dec_state_t DEC_RESET = '{
		phase:           PH_IDLE,
		header_mark:     16'd0,
		fmt:             FMT_NEC,
		bit_mark:        16'd0,
		mark_pending:    1'b0,
		shift_high:      32'd0,
		shift_low:       16'd0,
		bit_counter:     6'd0,
		manchester_prev: 1'b1
	};

	typedef struct packed {
		logic [1:0]        frame_status;
		logic [2:0]        format_code;
		logic [31:0]       word_high;
		logic [15:0]       word_low;
		logic [CountW-1:0] bits_received;
	} result_t;

	function automatic logic win(input ticks_t v, input ticks_t lo, input ticks_t hi);
		win = (v > lo) && (v < hi);
	endfunction

	function automatic logic [CountW-1:0] frame_len(input logic [2:0] fmt);
		unique case (fmt)
			FMT_SIRC, FMT_RC5: frame_len = LEN_SHORT;
			FMT_JAP:           frame_len = LEN_JAP;
			default:           frame_len = LEN_STD;
		endcase
	endfunction

	function automatic dec_state_t shift_in(input dec_state_t s, input logic b);
		dec_state_t r;
		r = s;
		if (s.fmt == FMT_JAP && s.bit_counter >= LEN_STD) begin
			r.shift_low = {s.shift_low[14:0], b};
		end else begin
			r.shift_high = {s.shift_high[30:0], b};
		end
		r.bit_counter = s.bit_counter + 6'd1;
		shift_in = r;
	endfunction

	// Bit value from a mark/space pair: 2'b0x is the bit, 2'b10 is an error.
	function automatic logic [1:0] pair_bit(input logic [2:0] fmt, input ticks_t m,
			input ticks_t s);
		logic one;
		logic zero;
		unique case (fmt)
			FMT_NEC: begin
				one  = win(m, 16'd450, 16'd650) && win(s, 16'd1400, 16'd1655);
				zero = win(m, 16'd450, 16'd650) && win(s, 16'd390, 16'd600);
			end
			FMT_SIRC: begin
				one  = win(m, 16'd1050, 16'd1250) && win(s, 16'd400, 16'd620);
				zero = win(m, 16'd400, 16'd620) && win(s, 16'd400, 16'd620);
			end
			FMT_JAP: begin
				one  = win(m, 16'd300, 16'd500) && win(s, 16'd1000, 16'd1450);
				zero = win(m, 16'd300, 16'd500) && win(s, 16'd250, 16'd450);
			end
			default: begin
				one  = win(m, 16'd380, 16'd670) && win(s, 16'd1250, 16'd1750);
				zero = win(m, 16'd380, 16'd670) && win(s, 16'd300, 16'd650);
			end
		endcase
		if (one) begin
			pair_bit = 2'b01;
		end else if (zero) begin
			pair_bit = 2'b00;
		end else begin
			pair_bit = 2'b10;
		end
	endfunction

endpackage

[hw/rtl/irmpd_if.sv]
// Valid/ready channel interfaces for pulse items and decoded result items.
interface irmpd_pulse_if;
	logic                       valid;
	logic                       ready;
	logic                       pulse_level;
	logic [irmpd_pkg::TicksW-1:0] pulse_ticks;

	modport source(output valid, pulse_level, pulse_ticks, input ready);
	modport sink(input valid, pulse_level, pulse_ticks, output ready);
endinterface

interface irmpd_result_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   frame_status;
	logic [2:0]                   format_code;
	logic [31:0]                  word_high;
	logic [15:0]                  word_low;
	logic [irmpd_pkg::CountW-1:0] bits_received;

	modport source(output valid, frame_status, format_code, word_high, word_low,
		bits_received, input ready);
	modport sink(input valid, frame_status, format_code, word_high, word_low,
		bits_received, output ready);
endinterface

[hw/rtl/irmpd_decode.sv]
// Decoder state registers and the single-step pulse classification logic.
module irmpd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic                 level,
	input  irmpd_pkg::ticks_t    ticks,
	output logic                 res_valid,
	output irmpd_pkg::result_t   res
);

	irmpd_pkg::dec_state_t st_q;
	irmpd_pkg::dec_state_t nx;
	logic                  emit;
	logic [1:0]            status;
	logic                  lng;
	logic                  b;
	logic [1:0]            pb;

	always_comb begin
		nx     = st_q;
		emit   = 1'b0;
		status = irmpd_pkg::ST_UNKNOWN;
		lng    = irmpd_pkg::win(ticks, 16'd1500, 16'd1720);
		b      = 1'b0;
		pb     = irmpd_pkg::pair_bit(st_q.fmt, st_q.bit_mark, ticks);
		if (st_q.phase == irmpd_pkg::PH_HEADER) begin
			if (!level) begin
				nx.header_mark = ticks;
			end else begin
				nx.shift_high      = '0;
				nx.shift_low       = '0;
				nx.bit_counter     = '0;
				nx.mark_pending    = 1'b0;
				nx.manchester_prev = 1'b1;
				priority if (irmpd_pkg::win(st_q.header_mark, 16'd8800, 16'd9090)
						&& irmpd_pkg::win(ticks, 16'd4200, 16'd4570)) begin
					nx.fmt   = irmpd_pkg::FMT_NEC;
					nx.phase = irmpd_pkg::PH_DATA;
				end else if (irmpd_pkg::win(st_q.header_mark, 16'd2340, 16'd2480)
						&& irmpd_pkg::win(ticks, 16'd470, 16'd575)) begin
					nx.fmt   = irmpd_pkg::FMT_SIRC;
					nx.phase = irmpd_pkg::PH_DATA;
				end else if (irmpd_pkg::win(st_q.header_mark, 16'd680, 16'd970)
						&& irmpd_pkg::win(ticks, 16'd680, 16'd885)) begin
					nx.fmt   = irmpd_pkg::FMT_RC5;
					nx.phase = irmpd_pkg::PH_DATA;
				end else if (irmpd_pkg::win(st_q.header_mark, 16'd3300, 16'd3590)
						&& irmpd_pkg::win(ticks, 16'd1500, 16'd1695)) begin
					nx.fmt   = irmpd_pkg::FMT_JAP;
					nx.phase = irmpd_pkg::PH_DATA;
				end else if (irmpd_pkg::win(st_q.header_mark, 16'd4305, 16'd4695)
						&& irmpd_pkg::win(ticks, 16'd4200, 16'd4550)) begin
					nx.fmt   = irmpd_pkg::FMT_F45;
					nx.phase = irmpd_pkg::PH_DATA;
				end else begin
					nx.fmt = irmpd_pkg::FMT_NEC;
					emit   = 1'b1;
					status = irmpd_pkg::ST_UNKNOWN;
				end
			end
		end else if (st_q.phase != irmpd_pkg::PH_DATA) begin
			if (!level) begin
				nx.header_mark = ticks;
				nx.phase       = irmpd_pkg::PH_HEADER;
			end
		end else if (st_q.fmt == irmpd_pkg::FMT_RC5) begin
			if (!lng && !irmpd_pkg::win(ticks, 16'd600, 16'd970)) begin
				emit   = 1'b1;
				status = irmpd_pkg::ST_BIT_ERR;
			end else if (lng || !level) begin
				b                  = lng ? ~st_q.manchester_prev : st_q.manchester_prev;
				nx                 = irmpd_pkg::shift_in(st_q, b);
				nx.manchester_prev = b;
				if (nx.bit_counter >= irmpd_pkg::frame_len(st_q.fmt)) begin
					emit   = 1'b1;
					status = irmpd_pkg::ST_VALID;
				end
			end
		end else if (!level) begin
			if (st_q.fmt == irmpd_pkg::FMT_SIRC && st_q.bit_counter == irmpd_pkg::SIRC_LAST) begin
				// The last SIRC bit has no trailing space, so its mark decides it.
				emit = 1'b1;
				if (irmpd_pkg::win(ticks, 16'd1050, 16'd1250)
						|| irmpd_pkg::win(ticks, 16'd400, 16'd620)) begin
					b      = irmpd_pkg::win(ticks, 16'd1050, 16'd1250);
					nx     = irmpd_pkg::shift_in(st_q, b);
					status = irmpd_pkg::ST_VALID;
				end else begin
					status = irmpd_pkg::ST_BIT_ERR;
				end
			end else begin
				nx.bit_mark     = ticks;
				nx.mark_pending = 1'b1;
			end
		end else if (!st_q.mark_pending || pb[1]) begin
			emit   = 1'b1;
			status = irmpd_pkg::ST_BIT_ERR;
		end else begin
			nx              = irmpd_pkg::shift_in(st_q, pb[0]);
			nx.mark_pending = 1'b0;
			if (nx.bit_counter >= irmpd_pkg::frame_len(st_q.fmt)) begin
				emit   = 1'b1;
				status = irmpd_pkg::ST_VALID;
			end
		end

		res.frame_status  = status;
		res.format_code   = nx.fmt;
		res.word_high     = nx.shift_high;
		res.word_low      = nx.shift_low;
		res.bits_received = nx.bit_counter;
		if (emit) begin
			nx.phase        = irmpd_pkg::PH_IDLE;
			nx.mark_pending = 1'b0;
		end
	end

	assign res_valid = step_en && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= irmpd_pkg::DEC_RESET;
		end else if (step_en) begin
			st_q <= nx;
		end
	end

endmodule

[hw/rtl/irmpd_out_reg.sv]
// Result register that holds one decoded item until the consumer takes it.
module irmpd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  irmpd_pkg::result_t   din,
	output logic                 free,
	irmpd_result_if.source       result
);

	logic               valid_q;
	irmpd_pkg::result_t data_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= din;
		end
	end

	assign result.valid         = valid_q;
	assign result.frame_status  = data_q.frame_status;
	assign result.format_code   = data_q.format_code;
	assign result.word_high     = data_q.word_high;
	assign result.word_low      = data_q.word_low;
	assign result.bits_received = data_q.bits_received;

endmodule

[hw/rtl/ir_remote_multi_protocol_decoder.sv]
// Top level of the infrared remote decoder for NEC, SIRC, RC5 and two further formats.
//
//   Channel  Role    Item
//   pulse    sink    pulse_level, pulse_ticks
//   result   source  frame_status, format_code, word_high, word_low, bits_received
//
// A pulse item is decoded while it sits in the input register, and its result is loaded
// into the result register at the edge where the decoder state advances. One pulse item
// is taken every cycle while no held result stalls; the step logic of the decoder state
// sets that rate. While a result is held and not taken, no pulse item is decoded, and
// the input stalls once the input register holds an item.
// Reset returns the decoder to idle and empties both registers.
module ir_remote_multi_protocol_decoder (
	input  logic            clk,
	input  logic            arst_n,
	irmpd_pulse_if.sink     pulse,
	irmpd_result_if.source  result
);

	logic               valid_s1;
	logic               level_s1;
	irmpd_pkg::ticks_t  ticks_s1;
	logic               out_free;
	logic               advance;
	logic               res_valid;
	irmpd_pkg::result_t res;

	assign advance     = valid_s1 && out_free;
	assign pulse.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse.ready) begin
			valid_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.ready && pulse.valid) begin
			level_s1 <= pulse.pulse_level;
			ticks_s1 <= pulse.pulse_ticks;
		end
	end

	irmpd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.level     (level_s1),
		.ticks     (ticks_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	irmpd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.din    (res),
		.free   (out_free),
		.result (result)
	);

endmodule

[hw/rtl/irmpd_checker.sv]
// Port-level assertions for the infrared remote decoder, bound to its top level.
module irmpd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   frame_status,
	input logic [2:0]                   format_code,
	input logic [31:0]                  word_high,
	input logic [15:0]                  word_low,
	input logic [irmpd_pkg::CountW-1:0] bits_received
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_high) && $stable(frame_status))
		else $error("Result item changed while stalled.");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == irmpd_pkg::ST_UNKNOWN |->
		format_code == irmpd_pkg::FMT_NEC && word_high == 32'd0 && word_low == 16'd0
		&& bits_received == '0)
		else $error("Unrecognised header item carries data.");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == irmpd_pkg::ST_VALID |->
		(bits_received == irmpd_pkg::frame_len(format_code)))
		else $error("Valid frame item has the wrong bit count.");

	a_low_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_code != irmpd_pkg::FMT_JAP |-> word_low == 16'd0)
		else $error("Low word set outside the 48-bit format.");

endmodule

bind ir_remote_multi_protocol_decoder irmpd_checker u_irmpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.frame_status  (result.frame_status),
	.format_code   (result.format_code),
	.word_high     (result.word_high),
	.word_low      (result.word_low),
	.bits_received (result.bits_received)
);
